// File: hw/rtl/smx_pkg.sv
`timescale 1ns / 1ps
package smx_pkg;

   localparam int MaxLen = 64;
   localparam int IdxW   = $clog2(MaxLen);
   localparam int CntW   = IdxW + 1;

   localparam logic [15:0] H_QNAN = 16'h7E00;
   localparam logic [15:0] H_INF  = 16'h7C00;
   localparam logic [15:0] H_COEF = 16'h65CF;
   localparam logic [15:0] H_BIAS = 16'h7380;
   localparam logic [15:0] H_SIGN = 16'h8000;

   typedef enum logic [2:0] {
      OP_ADD = 3'b001,
      OP_MUL = 3'b010,
      OP_DIV = 3'b100
   } op_type;

   typedef struct packed {
      logic        go;
      op_type      op;
      logic [15:0] a;
      logic [15:0] b;
   } fpu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [15:0] res;
   } fpu_res_type;

   function automatic logic h_isnan(input logic [15:0] h);
      return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
   endfunction

   function automatic logic h_isinf(input logic [15:0] h);
      return h[14:0] == 15'h7C00;
   endfunction

   function automatic logic h_iszero(input logic [15:0] h);
      return h[14:0] == 15'd0;
   endfunction

   function automatic logic [15:0] h_key(input logic [15:0] h);
      return h[15] ? ~h : (h | H_SIGN);
   endfunction

   function automatic logic [15:0] h_maxnum(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] r;
      if (h_isnan(a) && h_isnan(b)) r = H_QNAN;
      else if (h_isnan(a)) r = b;
      else if (h_isnan(b)) r = a;
      else r = (h_key(a) >= h_key(b)) ? a : b;
      return r;
   endfunction

   function automatic logic [15:0] h_to_u16(input logic [15:0] h);
      logic [4:0]  e;
      logic [15:0] mw;
      logic [15:0] r;
      e  = h[14:10];
      mw = {5'd0, 1'b1, h[9:0]};
      if (h_isnan(h)) r = 16'hFFFF;
      else if (h[15]) r = 16'd0;
      else if (e == 5'd31) r = 16'hFFFF;
      else if (e < 5'd15) r = 16'd0;
      else if (e <= 5'd25) r = mw >> (5'd25 - e);
      else r = mw << (e - 5'd25);
      return r;
   endfunction

endpackage

// File: hw/rtl/softmax_fp16_fast_exp.sv
`timescale 1ns / 1ps
// Channel   Ports                                           Direction
// req       req_valid req_ready req_sample_bits req_row_end  in
// rsp       rsp_valid rsp_ready rsp_prob_bits rsp_final_out
//           rsp_overflowed                                    out
// Samples load at one beat per cycle. After the row end, each sample passes through
// the shared fp unit in turn (subtract, multiply, add, sum); once the row total is
// known, each is divided by it (36-step restoring divider), and each result is held
// for any rsp stall. req_ready stays low from the row end until the last rsp beat.
// Reset is synchronous; the row store needs no clearing pass.
module softmax_fp16_fast_exp import smx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_sample_bits,
   input  logic        req_row_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_prob_bits,
   output logic        rsp_final_out,
   output logic        rsp_overflowed
);

   typedef enum logic [10:0] {
      S_LOAD = 11'b00000000001,
      S_RD   = 11'b00000000010,
      S_RDW  = 11'b00000000100,
      S_SUB  = 11'b00000001000,
      S_MUL  = 11'b00000010000,
      S_BIAS = 11'b00000100000,
      S_ACC  = 11'b00001000000,
      S_DRD  = 11'b00010000000,
      S_DRDW = 11'b00100000000,
      S_DIV  = 11'b01000000000,
      S_OUT  = 11'b10000000000
   } st_type;

   st_type            st_ff, st_in;
   logic [15:0]       mem [MaxLen];
   logic [15:0]       rd_ff;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic [15:0]       max_ff, max_in;
   logic [15:0]       tot_ff, tot_in;
   logic              drop_ff, drop_in;
   fpu_cmd_type       cmd_ff, cmd_in;
   fpu_res_type       fres;
   logic [15:0]       out_ff, out_in;
   logic              fin_ff, fin_in;
   logic              ovf_ff, ovf_in;
   logic              vld_ff, vld_in;
   logic              we;
   logic [IdxW-1:0]   wa;
   logic [15:0]       wd;
   logic              acc, room, lastidx;
   logic [15:0]       ex;

   smx_fpu u_fpu (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .res   (fres)
   );

   always_comb begin
      acc     = req_valid && (st_ff == S_LOAD);
      room    = cnt_ff < CntW'(MaxLen);
      lastidx = (CntW'(idx_ff) + CntW'(1)) == cnt_ff;
      ex      = h_to_u16(fres.res);
      st_in   = st_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      max_in  = max_ff;
      tot_in  = tot_ff;
      drop_in = drop_ff;
      cmd_in  = cmd_ff;
      cmd_in.go = 1'b0;
      out_in  = out_ff;
      fin_in  = fin_ff;
      ovf_in  = ovf_ff;
      vld_in  = vld_ff;
      we      = 1'b0;
      wa      = idx_ff;
      wd      = ex;
      unique case (st_ff)
         S_LOAD: begin
            if (acc) begin
               if (room) begin
                  we     = 1'b1;
                  wa     = cnt_ff[IdxW-1:0];
                  wd     = req_sample_bits;
                  max_in = (cnt_ff == CntW'(0)) ? h_maxnum(req_sample_bits, req_sample_bits)
                                               : h_maxnum(max_ff, req_sample_bits);
                  cnt_in = cnt_ff + CntW'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_row_end) begin
                  idx_in = '0;
                  tot_in = 16'd0;
                  st_in  = S_RD;
               end
            end
         end
         S_RD: st_in = S_RDW;
         S_RDW: begin
            cmd_in = '{go: 1'b1, op: OP_ADD, a: rd_ff, b: max_ff ^ H_SIGN};
            st_in  = S_SUB;
         end
         S_SUB: begin
            if (fres.done) begin
               cmd_in = '{go: 1'b1, op: OP_MUL, a: fres.res, b: H_COEF};
               st_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (fres.done) begin
               cmd_in = '{go: 1'b1, op: OP_ADD, a: fres.res, b: H_BIAS};
               st_in  = S_BIAS;
            end
         end
         S_BIAS: begin
            if (fres.done) begin
               we     = 1'b1;
               cmd_in = '{go: 1'b1, op: OP_ADD, a: tot_ff, b: ex};
               st_in  = S_ACC;
            end
         end
         S_ACC: begin
            if (fres.done) begin
               tot_in = fres.res;
               if (lastidx) begin
                  idx_in = '0;
                  st_in  = S_DRD;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
                  st_in  = S_RD;
               end
            end
         end
         S_DRD: st_in = S_DRDW;
         S_DRDW: begin
            cmd_in = '{go: 1'b1, op: OP_DIV, a: rd_ff, b: tot_ff};
            st_in  = S_DIV;
         end
         S_DIV: begin
            if (fres.done) begin
               out_in = fres.res;
               fin_in = lastidx;
               ovf_in = drop_ff;
               vld_in = 1'b1;
               st_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_ready) begin
               vld_in = 1'b0;
               if (fin_ff) begin
                  cnt_in  = '0;
                  max_in  = 16'd0;
                  tot_in  = 16'd0;
                  drop_in = 1'b0;
                  st_in   = S_LOAD;
               end else begin
                  idx_in = idx_ff + IdxW'(1);
                  st_in  = S_DRD;
               end
            end
         end
         default: st_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[wa] <= wd;
      rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_LOAD;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         max_ff    <= 16'd0;
         tot_ff    <= 16'd0;
         drop_ff   <= 1'b0;
         cmd_ff.go <= 1'b0;
         vld_ff    <= 1'b0;
      end else begin
         st_ff     <= st_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         max_ff    <= max_in;
         tot_ff    <= tot_in;
         drop_ff   <= drop_in;
         cmd_ff.go <= cmd_in.go;
         vld_ff    <= vld_in;
      end
      cmd_ff.op <= cmd_in.op;
      cmd_ff.a  <= cmd_in.a;
      cmd_ff.b  <= cmd_in.b;
      out_ff    <= out_in;
      fin_ff    <= fin_in;
      ovf_ff    <= ovf_in;
   end

   assign req_ready      = (st_ff == S_LOAD);
   assign rsp_valid      = vld_ff;
   assign rsp_prob_bits  = out_ff;
   assign rsp_final_out  = fin_ff;
   assign rsp_overflowed = ovf_ff;

endmodule

// File: hw/rtl/smx_fpu.sv
`timescale 1ns / 1ps
module smx_fpu import smx_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  fpu_cmd_type cmd,
   output fpu_res_type res
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_ITER = 3'b010,
      F_RND  = 3'b100
   } fst_type;

   fst_type            st_ff, st_in;
   logic               spec_ff, spec_in;
   logic [15:0]        sval_ff, sval_in;
   logic               sign_ff, sign_in;
   logic [39:0]        mant_ff, mant_in;
   logic signed [7:0]  xexp_ff, xexp_in;
   logic [10:0]        rem_ff, rem_in;
   logic [10:0]        den_ff, den_in;
   logic [10:0]        num_ff, num_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic [15:0]        res_ff, res_in;
   logic               done_ff, done_in;

   logic [4:0]  ea, eb, ebia, ebib, emin;
   logic [10:0] ma, mb;
   logic        sa, sb, sg;
   logic [39:0] aw, bw;

   always_comb begin
      ea   = cmd.a[14:10];
      eb   = cmd.b[14:10];
      ma   = {ea != 5'd0, cmd.a[9:0]};
      mb   = {eb != 5'd0, cmd.b[9:0]};
      ebia = (ea == 5'd0) ? 5'd1 : ea;
      ebib = (eb == 5'd0) ? 5'd1 : eb;
      emin = (ebia < ebib) ? ebia : ebib;
      sa   = cmd.a[15];
      sb   = cmd.b[15];
      sg   = sa ^ sb;
      aw   = 40'(ma) << (ebia - emin);
      bw   = 40'(mb) << (ebib - emin);
   end

   logic [11:0] rr;
   logic        nbit;

   always_comb begin
      nbit = (cnt_ff >= 6'd25) ? num_ff[4'(cnt_ff - 6'd25)] : 1'b0;
      rr   = {rem_ff, nbit};
   end

   logic [5:0]         lead;
   logic signed [9:0]  e, u, s;
   logic [63:0]        mx, rsh;
   logic [11:0]        r12;
   logic               g, rest, up;
   logic [16:0]        bb;
   logic [15:0]        rnd;

   always_comb begin
      lead = 6'd0;
      for (int i = 0; i < 40; i++) begin
         if (mant_ff[i]) lead = 6'(i);
      end
      e    = $signed({4'd0, lead}) + 10'(xexp_ff);
      u    = (e - 10'sd10 > -10'sd24) ? e - 10'sd10 : -10'sd24;
      s    = u - 10'(xexp_ff);
      mx   = {24'd0, mant_ff};
      g    = 1'b0;
      rest = 1'b0;
      up   = 1'b0;
      if (s <= 10'sd0) begin
         rsh = mx << 6'(-s);
      end else begin
         rsh  = mx >> 6'(s);
         g    = mx[6'(s - 10'sd1)];
         rest = ((mx & ((64'd1 << 6'(s - 10'sd1)) - 64'd1)) != 64'd0) || (rem_ff != 11'd0);
         up   = g & (rest | rsh[0]);
      end
      r12 = rsh[11:0] + 12'(up);
      if (e >= -10'sd14) begin
         bb = ({12'd0, 5'(e + 10'sd15)} << 10) + 17'(r12) - 17'd1024;
      end else begin
         bb = 17'(r12);
      end
      if (spec_ff) rnd = sval_ff;
      else if (e > 10'sd15 || bb >= 17'h07C00) rnd = {sign_ff, H_INF[14:0]};
      else rnd = {sign_ff, bb[14:0]};
   end

   always_comb begin
      st_in   = st_ff;
      spec_in = spec_ff;
      sval_in = sval_ff;
      sign_in = sign_ff;
      mant_in = mant_ff;
      xexp_in = xexp_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      res_in  = res_ff;
      done_in = 1'b0;
      unique case (st_ff)
         F_IDLE: begin
            if (cmd.go) begin
               st_in   = F_RND;
               spec_in = 1'b0;
               rem_in  = 11'd0;
               unique case (cmd.op)
                  OP_ADD: begin
                     xexp_in = 8'(emin) - 8'sd25;
                     if (h_isnan(cmd.a) || h_isnan(cmd.b)) begin
                        spec_in = 1'b1;
                        sval_in = H_QNAN;
                     end else if (h_isinf(cmd.a) && h_isinf(cmd.b)) begin
                        spec_in = 1'b1;
                        sval_in = sg ? H_QNAN : cmd.a;
                     end else if (h_isinf(cmd.a)) begin
                        spec_in = 1'b1;
                        sval_in = cmd.a;
                     end else if (h_isinf(cmd.b)) begin
                        spec_in = 1'b1;
                        sval_in = cmd.b;
                     end else begin
                        if (!sg) begin
                           mant_in = aw + bw;
                           sign_in = sa;
                        end else if (aw >= bw) begin
                           mant_in = aw - bw;
                           sign_in = sa;
                        end else begin
                           mant_in = bw - aw;
                           sign_in = sb;
                        end
                        if (mant_in == 40'd0) begin
                           spec_in = 1'b1;
                           sval_in = {sa & sb, 15'd0};
                        end
                     end
                  end
                  OP_MUL: begin
                     xexp_in = 8'(ebia) + 8'(ebib) - 8'sd50;
                     mant_in = 40'(ma * mb);
                     sign_in = sg;
                     if (h_isnan(cmd.a) || h_isnan(cmd.b)) begin
                        spec_in = 1'b1;
                        sval_in = H_QNAN;
                     end else if (h_isinf(cmd.a) || h_isinf(cmd.b)) begin
                        spec_in = 1'b1;
                        sval_in = (h_iszero(cmd.a) || h_iszero(cmd.b)) ? H_QNAN
                                                                    : {sg, H_INF[14:0]};
                     end else if (h_iszero(cmd.a) || h_iszero(cmd.b)) begin
                        spec_in = 1'b1;
                        sval_in = {sg, 15'd0};
                     end
                  end
                  OP_DIV: begin
                     xexp_in = 8'(ebia) - 8'(ebib) - 8'sd25;
                     sign_in = sg;
                     mant_in = 40'd0;
                     num_in  = ma;
                     den_in  = mb;
                     cnt_in  = 6'd35;
                     if (h_isnan(cmd.a) || h_isnan(cmd.b)) begin
                        spec_in = 1'b1;
                        sval_in = H_QNAN;
                     end else if (h_isinf(cmd.a)) begin
                        spec_in = 1'b1;
                        sval_in = h_isinf(cmd.b) ? H_QNAN : {sg, H_INF[14:0]};
                     end else if (h_isinf(cmd.b)) begin
                        spec_in = 1'b1;
                        sval_in = {sg, 15'd0};
                     end else if (h_iszero(cmd.b)) begin
                        spec_in = 1'b1;
                        sval_in = h_iszero(cmd.a) ? H_QNAN : {sg, H_INF[14:0]};
                     end else if (h_iszero(cmd.a)) begin
                        spec_in = 1'b1;
                        sval_in = {sg, 15'd0};
                     end else begin
                        st_in = F_ITER;
                     end
                  end
                  default: begin
                     spec_in = 1'b1;
                     sval_in = H_QNAN;
                  end
               endcase
            end
         end
         F_ITER: begin
            if (rr >= {1'b0, den_ff}) begin
               rem_in  = 11'(rr - {1'b0, den_ff});
               mant_in = {mant_ff[38:0], 1'b1};
            end else begin
               rem_in  = rr[10:0];
               mant_in = {mant_ff[38:0], 1'b0};
            end
            if (cnt_ff == 6'd0) st_in = F_RND;
            else cnt_in = cnt_ff - 6'd1;
         end
         F_RND: begin
            res_in  = rnd;
            done_in = 1'b1;
            st_in   = F_IDLE;
         end
         default: st_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= F_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      spec_ff <= spec_in;
      sval_ff <= sval_in;
      sign_ff <= sign_in;
      mant_ff <= mant_in;
      xexp_ff <= xexp_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      cnt_ff  <= cnt_in;
      res_ff  <= res_in;
   end

   assign res.done = done_ff;
   assign res.res  = res_ff;

endmodule

// File: hw/rtl/smx_chk.sv
`timescale 1ns / 1ps
module smx_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [15:0] req_sample_bits,
   input logic        req_row_end,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_prob_bits,
   input logic        rsp_final_out,
   input logic        rsp_overflowed
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_row_end_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_row_end) |=> !req_ready)
      else $error("ready after row end beat");

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_final_out) |=> (!rsp_valid && req_ready))
      else $error("not back to load after final beat");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_prob_bits)))
      else $error("stalled result changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind softmax_fp16_fast_exp smx_chk u_smx_chk (.*);

// File: test/tb_softmax_fp16_fast_exp.sv
`timescale 1ns / 1ps
module tb_softmax_fp16_fast_exp;
   import smx_pkg::*;

   typedef struct packed {
      logic [15:0] prob;
      logic        fin;
      logic        ovf;
   } prob_beat_type;

   typedef struct packed {
      logic [15:0] smp;
      logic        last;
      logic        typed;
      logic [15:0] prob;
   } dir_row_type;

   localparam int NDir = 23;

   dir_row_type dir_tab [0:NDir-1] = '{
      '{16'h0000, 1'b1, 1'b1, 16'h3C00},
      '{16'h8000, 1'b1, 1'b1, 16'h3C00},
      '{16'h7BFF, 1'b1, 1'b1, 16'h3C00},
      '{16'hFBFF, 1'b1, 1'b1, 16'h3C00},
      '{16'h7C00, 1'b1, 1'b1, 16'h7E00},
      '{16'hFC00, 1'b1, 1'b1, 16'h7E00},
      '{16'h7E01, 1'b1, 1'b1, 16'h7E00},
      '{16'h0001, 1'b0, 1'b0, 16'h0000},
      '{16'h8001, 1'b0, 1'b0, 16'h0000},
      '{16'h8000, 1'b0, 1'b0, 16'h0000},
      '{16'h0000, 1'b1, 1'b0, 16'h0000},
      '{16'h7E00, 1'b0, 1'b0, 16'h0000},
      '{16'h4000, 1'b1, 1'b0, 16'h0000},
      '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
      '{16'h7C01, 1'b1, 1'b0, 16'h0000},
      '{16'h4900, 1'b0, 1'b0, 16'h0000},
      '{16'hC900, 1'b0, 1'b0, 16'h0000},
      '{16'h3C00, 1'b0, 1'b0, 16'h0000},
      '{16'h7C00, 1'b1, 1'b0, 16'h0000},
      '{16'h3555, 1'b0, 1'b0, 16'h0000},
      '{16'h3C00, 1'b0, 1'b0, 16'h0000},
      '{16'h4000, 1'b0, 1'b0, 16'h0000},
      '{16'h4200, 1'b1, 1'b0, 16'h0000}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_sample_bits = '0;
   logic        req_row_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_prob_bits;
   logic        rsp_final_out;
   logic        rsp_overflowed;

   prob_beat_type prob_q [$];
   logic [15:0] row_buf [$];
   logic [15:0] row_peak;
   logic        row_dropped;
   int          n_err;
   int          n_rows;
   int          n_probs;
   int          n_ovf_rows;
   int          n_items;

   softmax_fp16_fast_exp i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic is_nan(logic [15:0] h);
      return h[14:10] == 5'h1F && h[9:0] != 10'd0;
   endfunction

   function automatic logic is_inf(logic [15:0] h);
      return h[14:0] == 15'h7C00;
   endfunction

   function automatic logic is_zero(logic [15:0] h);
      return h[14:0] == 15'd0;
   endfunction

   function automatic real half_real(logic [15:0] h);
      logic [63:0] b;
      real         d;
      if (h[14:10] == 5'd0) begin
         d = real'(h[9:0]) / 16777216.0;
      end else begin
         b = ({59'd0, h[14:10]} + 64'd1008) << 52 | ({54'd0, h[9:0]} << 42);
         d = $bitstoreal(b);
      end
      return h[15] ? -d : d;
   endfunction

   function automatic logic [15:0] real_half(real d);
      logic [63:0] b, m, r, rem, hb;
      logic [15:0] sg;
      logic [31:0] bits;
      int          e, u, s;
      b  = $realtobits(d);
      sg = {b[63], 15'd0};
      if (b[62:52] == 11'd0) return sg;
      e = int'(b[62:52]) - 1023;
      m = {12'd1, b[51:0]};
      if (e > 15) return sg | H_INF;
      u = (e - 10 > -24) ? e - 10 : -24;
      s = u - e + 52;
      if (s > 54) return sg;
      r   = m >> s;
      rem = m & ((64'd1 << s) - 64'd1);
      hb  = 64'd1 << (s - 1);
      if (rem > hb || (rem == hb && r[0])) r = r + 64'd1;
      if (e >= -14) bits = 32'((e + 15) << 10) + r[31:0] - 32'd1024;
      else bits = r[31:0];
      if (bits >= 32'h7C00) bits = 32'h7C00;
      return sg | bits[15:0];
   endfunction

   function automatic logic [15:0] fp_add(logic [15:0] a, logic [15:0] b);
      if (is_nan(a) || is_nan(b)) return H_QNAN;
      if (is_inf(a) && is_inf(b)) return (a[15] ^ b[15]) ? H_QNAN : a;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      return real_half(half_real(a) + half_real(b));
   endfunction

   function automatic logic [15:0] fp_mul(logic [15:0] a, logic [15:0] b);
      if (is_nan(a) || is_nan(b)) return H_QNAN;
      if (is_inf(a) || is_inf(b))
         return (is_zero(a) || is_zero(b)) ? H_QNAN : ({a[15] ^ b[15], 15'd0} | H_INF);
      return real_half(half_real(a) * half_real(b));
   endfunction

   function automatic logic [15:0] fp_div(logic [15:0] a, logic [15:0] b);
      logic [15:0] sg;
      sg = {a[15] ^ b[15], 15'd0};
      if (is_nan(a) || is_nan(b)) return H_QNAN;
      if (is_inf(a)) return is_inf(b) ? H_QNAN : (sg | H_INF);
      if (is_inf(b)) return sg;
      if (is_zero(b)) return is_zero(a) ? H_QNAN : (sg | H_INF);
      if (is_zero(a)) return sg;
      return real_half(half_real(a) / half_real(b));
   endfunction

   function automatic logic [15:0] order_key(logic [15:0] h);
      return h[15] ? ~h : (h | H_SIGN);
   endfunction

   function automatic logic [15:0] fp_max(logic [15:0] a, logic [15:0] b);
      if (is_nan(a) && is_nan(b)) return H_QNAN;
      if (is_nan(a)) return b;
      if (is_nan(b)) return a;
      return (order_key(a) >= order_key(b)) ? a : b;
   endfunction

   function automatic logic [15:0] trunc_u16(logic [15:0] h);
      logic [15:0] mw;
      mw = {5'd0, 1'b1, h[9:0]};
      if (is_nan(h)) return 16'hFFFF;
      if (h[15]) return 16'd0;
      if (h[14:10] == 5'd31) return 16'hFFFF;
      if (h[14:10] < 5'd15) return 16'd0;
      if (h[14:10] <= 5'd25) return mw >> (5'd25 - h[14:10]);
      return mw << (h[14:10] - 5'd25);
   endfunction

   task automatic predict_softmax(logic [15:0] x, logic last);
      logic [15:0] ex [$];
      logic [15:0] t, total;
      prob_beat_type pb;
      if (row_buf.size() < MaxLen) begin
         row_peak = (row_buf.size() == 0) ? fp_max(x, x) : fp_max(row_peak, x);
         row_buf.push_back(x);
      end else begin
         row_dropped = 1'b1;
      end
      if (last) begin
         total = 16'd0;
         foreach (row_buf[i]) begin
            t = fp_add(row_buf[i], row_peak ^ H_SIGN);
            t = fp_mul(t, H_COEF);
            t = fp_add(t, H_BIAS);
            ex.push_back(trunc_u16(t));
            total = fp_add(total, ex[i]);
         end
         foreach (ex[i]) begin
            pb.prob = fp_div(ex[i], total);
            pb.fin  = (i == ex.size() - 1);
            pb.ovf  = row_dropped;
            prob_q.push_back(pb);
         end
         n_rows++;
         if (row_dropped) n_ovf_rows++;
         row_buf.delete();
         row_dropped = 1'b0;
      end
   endtask

   task automatic report(string what, logic [15:0] got, logic [15:0] want);
      n_err++;
      $display("mismatch %s: got %h want %h", what, got, want);
   endtask

   task automatic send_sample(logic [15:0] x, logic last);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_sample_bits <= x;
      req_row_end     <= last;
      do @(posedge clock); while (!req_ready);
      n_items++;
      predict_softmax(x, last);
   endtask

   task automatic idle_req(int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_sample();
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) return {1'($urandom), 5'($urandom_range(10, 18)), 10'($urandom)};
      if (k == 6) return {1'($urandom), 5'h1F, 10'($urandom_range(0, 3))};
      return 16'($urandom);
   endfunction

   always @(posedge clock) begin
      prob_beat_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (prob_q.size() == 0) begin
            report("unexpected beat", rsp_prob_bits, 16'h0000);
         end else begin
            w = prob_q.pop_front();
            n_probs++;
            if (rsp_prob_bits !== w.prob) report("prob_bits", rsp_prob_bits, w.prob);
            if (rsp_final_out !== w.fin) report("final_out", 16'(rsp_final_out), 16'(w.fin));
            if (rsp_overflowed !== w.ovf)
               report("overflowed", 16'(rsp_overflowed), 16'(w.ovf));
         end
      end
   end

   always @(negedge clock) begin
      int mode;
      int cyc;
      cyc++;
      if (cyc % 97 == 0) mode = $urandom_range(0, 3);
      case (mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= ((cyc / 5) % 3 != 0);
      endcase
   end

   initial begin
      #1_000_000;
      $display("tb_softmax_fp16_fast_exp: errors");
      $finish;
   end

   initial begin
      int len, burst, wait_c;
      row_dropped = 1'b0;
      row_peak    = 16'd0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < NDir; i++) begin
         send_sample(dir_tab[i].smp, dir_tab[i].last);
         if (dir_tab[i].typed) prob_q[$].prob = dir_tab[i].prob;
         if ($urandom_range(0, 2) == 0) idle_req($urandom_range(1, 4));
      end

      burst = $urandom_range(1, 10);
      while (n_items < 250) begin
         case ($urandom_range(0, 19))
            0, 1:    len = $urandom_range(20, 64);
            2:       len = $urandom_range(65, 72);
            default: len = $urandom_range(1, 12);
         endcase
         for (int j = 0; j < len; j++) begin
            send_sample(rand_sample(), j == len - 1);
            if (--burst == 0) begin
               idle_req($urandom_range(1, 6));
               burst = $urandom_range(1, 12);
            end
         end
         if (n_rows == 20) begin
            idle_req(1);
            wait (prob_q.size() == 0);
            repeat (20) @(negedge clock);
         end
      end
      idle_req(1);

      wait_c = 0;
      while (prob_q.size() != 0 && wait_c < 400000) begin
         @(posedge clock);
         wait_c++;
      end
      repeat (200) @(posedge clock);
      if (prob_q.size() != 0) begin
         n_err++;
         $display("%0d expected beats never arrived", prob_q.size());
      end
      $display("covered %0d samples in %0d rows, %0d with dropped samples", n_items, n_rows,
               n_ovf_rows);
      $display("checked %0d probability beats, %0d mismatches", n_probs, n_err);
      if (n_err == 0) begin
         $display("tb_softmax_fp16_fast_exp: clean");
      end else begin
         $display("tb_softmax_fp16_fast_exp: errors");
      end
      $finish;
   end

endmodule

// File: softmax_fp16_fast_exp.f
hw/rtl/smx_pkg.sv
hw/rtl/smx_fpu.sv
hw/rtl/softmax_fp16_fast_exp.sv
hw/rtl/smx_chk.sv
test/tb_softmax_fp16_fast_exp.sv
